@@ design/assert_macros.svh @@
// Assertion macros used by the snapshot interpolation engine top.
// Needs clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked on every rising edge outside reset.
`define SIE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sie assertion failed");
// Implication checked across the next edge.
`define SIE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sie assertion failed");
`endif

@@ design/sie_pkg.sv @@
// Types and constants for the snapshot interpolation engine.
// No dependencies.
`default_nettype none
package sie_pkg;
  localparam int DEF_ENTITIES      = 16;
  localparam int DEF_HISTORY_DEPTH = 4;
  localparam int ENT_W   = 6;
  localparam int TIME_W  = 31;
  localparam int POS_W   = 32;
  localparam int ANG_W   = 16;
  localparam int PAR_W   = 16;
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 104;

  typedef struct packed {
    logic [TIME_W-1:0]       ts;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [ANG_W-1:0] angle;
    logic [PAR_W-1:0]        parent;
  } snap_t;

  typedef struct packed {
    logic              is_tick;
    logic [ENT_W-1:0]  entity;
    snap_t             snap;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [ENT_W-1:0]        entity;
    logic                    ok;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [ANG_W-1:0] angle;
    logic [PAR_W-1:0]        parent;
    logic                    last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SRD, S_SWR, S_TRD, S_TSRCH, S_TDIV, S_TMUL, S_TOUT
  } back_state_e;
endpackage
`default_nettype wire

@@ design/snapshot_interpolation_engine.sv @@
// Snapshot interpolation engine. A store passes S_SRD, then S_SWR in the back end.
// A tick walks the entities one at a time: an entity with no bracketing pair
// goes from search to output; one that interpolates runs a 16-step divider, then
// a shared multiplier for x, y, angle. Output stalls hold the walk at each
// entity's output. Reset clears control and per-entity valid flags;
// history reads as zero.
`default_nettype none
module snapshot_interpolation_engine #(
  parameter int ENTITIES      = sie_pkg::DEF_ENTITIES,
  parameter int HISTORY_DEPTH = sie_pkg::DEF_HISTORY_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // in_entity, snap_time, snap_x, snap_y, snap_angle, snap_parent, now_time
  input  wire logic [sie_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // req_type
  input  wire logic                           s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // out_entity, pred_x, pred_y, pred_angle, pred_parent
  output logic [sie_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // out_valid
  output logic                                m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);
  import sie_pkg::*;
  `include "assert_macros.svh"

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  sie_front #(.ENTITIES(ENTITIES)) u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  sie_back #(.ENTITIES(ENTITIES), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_o      (res)
  );

  assign m_axis_tdata_o = {2'b00, res.parent, res.angle, res.y, res.x, res.entity};
  assign m_axis_tuser_o = res.ok;
  assign m_axis_tlast_o = res.last;

  `SIE_ASSERT(a_invalid_zero, !(m_axis_tvalid_o && !m_axis_tuser_o) ||
    (m_axis_tdata_o[101:6] == '0))
  `SIE_ASSERT(a_last_entity, !(m_axis_tvalid_o && m_axis_tlast_o) ||
    (m_axis_tdata_o[5:0] == ENT_W'(ENTITIES - 1)))
  `SIE_ASSERT_NEXT(a_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o))
endmodule
`default_nettype wire

@@ design/sie_front.sv @@
// Front end: takes input words, drops out-of-range stores, queues commands.
// Depends on sie_pkg.
`default_nettype none
module sie_front #(
  parameter int ENTITIES = sie_pkg::DEF_ENTITIES
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_tvalid_i,
  output logic                              s_tready_o,
  input  wire logic [sie_pkg::IN_TDATA_W-1:0] s_tdata_i,
  input  wire logic                         s_tuser_i,
  output logic                              cmd_valid_o,
  output sie_pkg::cmd_t                     cmd_o,
  input  wire logic                         cmd_pop_i
);
  import sie_pkg::*;

  cmd_t       fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  cmd_t       in_cmd;
  logic       push, pop;

  always_comb begin
    in_cmd.is_tick     = s_tuser_i;
    in_cmd.entity      = s_tdata_i[5:0];
    in_cmd.snap.ts     = s_tdata_i[36:6];
    in_cmd.snap.x      = s_tdata_i[68:37];
    in_cmd.snap.y      = s_tdata_i[100:69];
    in_cmd.snap.angle  = s_tdata_i[116:101];
    in_cmd.snap.parent = s_tdata_i[132:117];
    in_cmd.now         = s_tdata_i[163:133];
  end

  assign s_tready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];
  // stores for entities beyond the table never reach the back end
  assign push = s_tvalid_i && s_tready_o &&
                (s_tuser_i || ({1'b0, in_cmd.entity} < 7'(ENTITIES)));
  assign pop  = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= in_cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

@@ design/sie_back.sv @@
// Back end: history memory, store update, tick walk with serial divider
// and shared multiplier, output register. Depends on sie_pkg.
`default_nettype none
module sie_back #(
  parameter int ENTITIES      = sie_pkg::DEF_ENTITIES,
  parameter int HISTORY_DEPTH = sie_pkg::DEF_HISTORY_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  sie_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sie_pkg::res_t      out_o
);
  import sie_pkg::*;

  localparam int EW = (ENTITIES > 1) ? $clog2(ENTITIES) : 1;
  localparam int KW = $clog2(HISTORY_DEPTH);
  localparam logic [KW-1:0] KLAST = KW'(HISTORY_DEPTH - 1);

  back_state_e state_q, state_d;

  snap_t [HISTORY_DEPTH-1:0] mem [ENTITIES];
  logic [ENTITIES-1:0]       rowv_q;
  snap_t [HISTORY_DEPTH-1:0] row_q, row, new_row;
  logic                      rowok_q;

  cmd_t              cmd_q;
  logic [EW-1:0]     addr_q;
  snap_t             from_q, to_q;
  logic [TIME_W-1:0] span_q, rem_q;
  logic [15:0]       quo_q;
  logic [3:0]        cnt_q;
  logic              ok_q;
  logic signed [POS_W-1:0] px_q, py_q;
  logic signed [ANG_W-1:0] pa_q;
  logic signed [49:0] prod_q;
  res_t              res_q;
  logic              res_v_q;

  logic              hit, newer, slot_free, is_last, mem_we, out_load;
  logic [KW-1:0]     k_idx, f_idx;
  logic [TIME_W:0]   r2;
  logic signed [32:0] a33, b33, diff33, sum33;

  assign row = rowok_q ? row_q : '0;

  // first snapshot, oldest first, that lies after the tick time
  always_comb begin
    logic found;
    found = 1'b0;
    k_idx = '0;
    for (int i = HISTORY_DEPTH - 1; i >= 0; i--) begin
      if (cmd_q.now < row[i].ts) begin
        found = 1'b1;
        k_idx = KW'(i);
      end
    end
    f_idx = k_idx - 1'b1;
    hit = found && (k_idx != '0) && (cmd_q.now != '0) && (row[KLAST].ts != '0) &&
          (row[k_idx].ts > row[f_idx].ts) && (cmd_q.now >= row[f_idx].ts);
  end

  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) new_row[i] = row[i+1];
    new_row[HISTORY_DEPTH-1] = cmd_q.snap;
  end

  assign newer     = row[KLAST].ts < cmd_q.snap.ts;
  assign slot_free = !res_v_q || out_ready_i;
  assign is_last   = (addr_q == EW'(ENTITIES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (cmd_valid_i) state_d = cmd_i.is_tick ? S_TRD : S_SRD;
      S_SRD:   state_d = S_SWR;
      S_SWR:   state_d = S_IDLE;
      S_TRD:   state_d = S_TSRCH;
      S_TSRCH: state_d = hit ? S_TDIV : S_TOUT;
      S_TDIV:  if (cnt_q == 4'd15) state_d = S_TMUL;
      S_TMUL:  if (cnt_q == 4'd5) state_d = S_TOUT;
      S_TOUT:  if (slot_free) state_d = is_last ? S_IDLE : S_TRD;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE:  cmd_pop_o = cmd_valid_i;
      S_SWR:   mem_we    = newer;
      S_TOUT:  out_load  = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rowv_q  <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) rowv_q[addr_q] <= 1'b1;
      if (out_load) res_v_q <= 1'b1;
      else if (out_ready_i) res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr_q] <= new_row;
    row_q   <= mem[addr_q];
    rowok_q <= rowv_q[addr_q];
  end

  // lerp operands: cnt[2:1] picks x, y, angle; even cycles multiply, odd add
  always_comb begin
    unique case (cnt_q[2:1])
      2'd0: begin
        a33 = 33'(from_q.x);
        b33 = 33'(to_q.x);
      end
      2'd1: begin
        a33 = 33'(from_q.y);
        b33 = 33'(to_q.y);
      end
      default: begin
        a33 = 33'(from_q.angle);
        b33 = 33'(to_q.angle);
      end
    endcase
    diff33 = b33 - a33;
    sum33  = a33 + prod_q[48:16];
    r2     = {rem_q, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q  <= cmd_i;
      addr_q <= cmd_i.is_tick ? '0 : cmd_i.entity[EW-1:0];
    end
    if (state_q == S_TSRCH) begin
      from_q <= row[f_idx];
      to_q   <= row[k_idx];
      span_q <= row[k_idx].ts - row[f_idx].ts;
      rem_q  <= cmd_q.now - row[f_idx].ts;
      ok_q   <= hit;
      cnt_q  <= '0;
    end
    if (state_q == S_TDIV) begin
      cnt_q <= cnt_q + 4'd1;
      if (r2 >= {1'b0, span_q}) begin
        rem_q <= TIME_W'(r2 - {1'b0, span_q});
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= r2[TIME_W-1:0];
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
    if (state_q == S_TMUL) begin
      cnt_q <= cnt_q + 4'd1;
      if (!cnt_q[0]) begin
        prod_q <= diff33 * $signed({1'b0, quo_q});
      end else begin
        unique case (cnt_q[2:1])
          2'd0:    px_q <= sum33[31:0];
          2'd1:    py_q <= sum33[31:0];
          default: pa_q <= sum33[15:0];
        endcase
      end
    end
    if (out_load) begin
      res_q.entity <= ENT_W'(addr_q);
      res_q.ok     <= ok_q;
      res_q.x      <= ok_q ? px_q : '0;
      res_q.y      <= ok_q ? py_q : '0;
      res_q.angle  <= ok_q ? pa_q : '0;
      res_q.parent <= ok_q ? from_q.parent : '0;
      res_q.last   <= is_last;
      if (!is_last) addr_q <= addr_q + 1'b1;
    end
  end

  assign out_valid_o = res_v_q;
  assign out_o       = res_q;
endmodule
`default_nettype wire
